// ===== rtl/rkx_pkg.sv =====
package rkx_pkg;

  localparam int KEY_BYTES_DEF = 1024;
  localparam int BYTE_W        = 8;
  localparam int SLOT_W        = 10;
  localparam int LEN_W         = 11;
  localparam int OFS_W         = 3;

  localparam logic [OFS_W-1:0] OFS_MAX = 3'd7;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

endpackage

// ===== rtl/rotating_key_xor_stream_core.sv =====
// An accepted data request is registered in stage 1 with its key RAM reads, then in the output register.
// Throughput: one request per cycle while in_stall is low; the two key bytes of a stream byte come
// from two copies of the key RAM read in the same cycle.
// Reset (rst, synchronous): stream position and rotation cleared, key length 1.
// Key RAM contents are not reset.
module rotating_key_xor_stream_core #(
  parameter int KEY_BYTES = rkx_pkg::KEY_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rkx_pkg::LEN_W-1:0]   key_length,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [rkx_pkg::SLOT_W-1:0]  key_slot,
  input  logic [rkx_pkg::BYTE_W-1:0]  byte_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rkx_pkg::BYTE_W-1:0]  cipher_byte
);

  localparam int AW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int LW = $clog2(KEY_BYTES + 1);

  logic [LW-1:0]                len;
  logic [AW-1:0]                pos;
  logic [AW-1:0]                cur_q;
  logic [AW-1:0]                base_q;
  logic [rkx_pkg::OFS_W-1:0]    base_o;

  logic                         s1_valid;
  logic [rkx_pkg::OFS_W-1:0]    s1_o;
  logic [rkx_pkg::BYTE_W-1:0]   s1_val;
  logic [rkx_pkg::BYTE_W-1:0]   key_lo;
  logic [rkx_pkg::BYTE_W-1:0]   key_hi;

  logic                         out_free;
  logic                         s1_free;
  logic                         accept;
  logic                         data_acc;
  logic                         key_wr;
  logic                         last;
  logic [AW-1:0]                q_inc;
  logic [AW-1:0]                len_m1;
  logic [AW-1:0]                base_q_next;
  logic [rkx_pkg::OFS_W-1:0]    base_o_next;
  logic [LW-1:0]                len_next;
  logic [2*rkx_pkg::BYTE_W-1:0] pair_sh;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid || !out_stall;
  assign s1_free  = !s1_valid || out_free;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;
  assign data_acc = accept && (req_type == rkx_pkg::REQ_DATA);
  assign key_wr   = accept && (req_type == rkx_pkg::REQ_KEY) && (32'(key_slot) < KEY_BYTES);

  assign len_m1 = AW'(32'(len) - 32'd1);
  assign last   = (32'(pos) + 32'd1) == 32'(len);
  assign q_inc  = ((32'(cur_q) + 32'd1) == 32'(len)) ? '0 : AW'(32'(cur_q) + 32'd1);

  // one bit further back per completed pass
  always_comb begin
    if (base_o == '0) begin
      base_o_next = rkx_pkg::OFS_MAX;
      base_q_next = (base_q == '0) ? len_m1 : AW'(32'(base_q) - 32'd1);
    end else begin
      base_o_next = base_o - 1'b1;
      base_q_next = base_q;
    end
  end

  always_comb begin
    if (key_length == '0) begin
      len_next = LW'(1);
    end else if (32'(key_length) > KEY_BYTES) begin
      len_next = LW'(KEY_BYTES);
    end else begin
      len_next = LW'(key_length);
    end
  end

  rkx_ram #(.WIDTH(rkx_pkg::BYTE_W), .DEPTH(KEY_BYTES)) u_ram_lo (
    .clk   (clk),
    .we    (key_wr),
    .waddr (AW'(key_slot)),
    .wdata (byte_value),
    .re    (data_acc),
    .raddr (cur_q),
    .rdata (key_lo)
  );

  rkx_ram #(.WIDTH(rkx_pkg::BYTE_W), .DEPTH(KEY_BYTES)) u_ram_hi (
    .clk   (clk),
    .we    (key_wr),
    .waddr (AW'(key_slot)),
    .wdata (byte_value),
    .re    (data_acc),
    .raddr (q_inc),
    .rdata (key_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= LW'(1);
      pos    <= '0;
      cur_q  <= '0;
      base_q <= '0;
      base_o <= '0;
    end else if (cfg_valid && cfg_ready) begin
      len    <= len_next;
      pos    <= '0;
      cur_q  <= '0;
      base_q <= '0;
      base_o <= '0;
    end else if (key_wr) begin
      pos    <= '0;
      cur_q  <= '0;
      base_q <= '0;
      base_o <= '0;
    end else if (data_acc) begin
      if (last) begin
        pos    <= '0;
        cur_q  <= base_q_next;
        base_q <= base_q_next;
        base_o <= base_o_next;
      end else begin
        pos   <= pos + 1'b1;
        cur_q <= q_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= data_acc;
    end
    if (data_acc) begin
      s1_o   <= base_o;
      s1_val <= byte_value;
    end
  end

  assign pair_sh = {key_hi, key_lo} >> s1_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (out_free && s1_valid) begin
      cipher_byte <= s1_val ^ pair_sh[rkx_pkg::BYTE_W-1:0];
    end
  end

`ifndef SYNTH
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (32'(pos) < 32'(len)) && (32'(cur_q) < 32'(len)))
    else $error("stream position beyond key length");

  a_key_restart: assert property (@(posedge clk) disable iff (rst)
    key_wr |=> (pos == '0) && (base_o == '0) && (cur_q == '0))
    else $error("key write did not restart stream");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid && $stable(s1_val))
    else $error("request lost in pipeline");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("request taken with pipeline full");
`endif

endmodule

// ===== rtl/rkx_ram.sv =====
module rkx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
